/* hw/rtl/qts_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the quoted token splitter.
// No dependencies; every other file imports this package.
package qts_pkg;

  localparam int NUM_DELIMS = 4;
  localparam int BUNDLE_SLOTS = 3;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_TOKEN  = 2'd1;
  localparam logic [1:0] KIND_STRING = 2'd2;

  // special characters
  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BS    = 8'h5C;
  localparam logic [7:0] CH_PCT   = 8'h25;

  // configuration register indexes
  localparam logic [1:0] REG_DELIM_A = 2'd0;
  localparam logic [1:0] REG_DELIM_B = 2'd1;
  localparam logic [1:0] REG_DELIM_C = 2'd2;
  localparam logic [1:0] REG_DELIM_D = 2'd3;

  localparam logic [7:0] DELIM_A_RESET = 8'd47;

  typedef logic [NUM_DELIMS-1:0][7:0] delim_set_t;

  typedef enum logic [2:0] {
    CL_PLAIN = 3'd0,
    CL_SQ    = 3'd1,
    CL_DQ    = 3'd2,
    CL_BS    = 3'd3,
    CL_PCT   = 3'd4,
    CL_DELIM = 3'd5,
    CL_END   = 3'd6
  } char_class_t;

  typedef enum logic [5:0] {
    ST_PLAIN = 6'b000001,
    ST_SQ    = 6'b000010,
    ST_DQ    = 6'b000100,
    ST_ESC   = 6'b001000,
    ST_PCT   = 6'b010000,
    ST_PCT2  = 6'b100000
  } parse_state_t;

  // up to three results caused by one input word
  typedef struct packed {
    logic [1:0]                        last_idx;
    logic [BUNDLE_SLOTS-1:0][7:0]      bytes;
    logic [BUNDLE_SLOTS-1:0][1:0]      kinds;
  } bundle_t;

  function automatic char_class_t classify(input logic [7:0] b, input delim_set_t d);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_DELIMS; i++) begin
      if (b == d[i]) hit = 1'b1;
    end
    if (b == CH_END) return CL_END;
    if (b == CH_SQ)  return CL_SQ;
    if (b == CH_DQ)  return CL_DQ;
    if (b == CH_BS)  return CL_BS;
    if (b == CH_PCT) return CL_PCT;
    if (hit)         return CL_DELIM;
    return CL_PLAIN;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      t = b - 8'h30;
      return {1'b1, t[3:0]};
    end
    if (b inside {[8'h41:8'h46]}) begin
      t = b - 8'h37;
      return {1'b1, t[3:0]};
    end
    if (b inside {[8'h61:8'h66]}) begin
      t = b - 8'h57;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

/* hw/rtl/qts_front.sv */
`timescale 1ns / 1ps
// Front end: classifies each input word, runs the parse state machine and
// builds the bundle of results it causes. Depends on qts_pkg.
module qts_front (
  input  logic               clk,
  input  logic               rst_n,
  input  qts_pkg::delim_set_t delims,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_ready,
  input  logic               q_full,
  output logic               push,
  output qts_pkg::bundle_t   push_bundle
);
  import qts_pkg::*;

  parse_state_t state_r, state_nxt, st_eff;
  logic [7:0]   held_r, held_nxt;
  char_class_t  cls;
  logic [4:0]   h1, h2;
  logic         done;
  logic [1:0]   pre_n;
  logic [7:0]   pre0, pre1;
  logic         tail_en;
  logic [7:0]   tail_b;
  logic [1:0]   tail_k;
  logic [1:0]   total;
  logic         accept;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign cls      = classify(in_byte, delims);
  assign h1       = hex_value(held_r);
  assign h2       = hex_value(in_byte);

  always_comb begin
    st_eff    = state_r;
    state_nxt = state_r;
    held_nxt  = held_r;
    done      = 1'b0;
    pre_n     = 2'd0;
    pre0      = CH_PCT;
    pre1      = held_r;
    tail_en   = 1'b0;
    tail_b    = 8'h00;
    tail_k    = KIND_DATA;

    case (state_r)
      ST_PCT: begin
        if (cls == CL_PLAIN) begin
          held_nxt  = in_byte;
          state_nxt = ST_PCT2;
          done      = 1'b1;
        end else begin
          pre_n  = 2'd1;
          st_eff = ST_PLAIN;
        end
      end
      ST_PCT2: begin
        held_nxt = 8'h00;
        if (cls == CL_PLAIN) begin
          done      = 1'b1;
          state_nxt = ST_PLAIN;
          if (h1[4] && h2[4]) begin
            pre_n = 2'd1;
            pre0  = {h1[3:0], h2[3:0]};
          end else begin
            pre_n   = 2'd2;
            tail_en = 1'b1;
            tail_b  = in_byte;
          end
        end else begin
          pre_n  = 2'd2;
          st_eff = ST_PLAIN;
        end
      end
      ST_SQ, ST_DQ, ST_ESC, ST_PLAIN: st_eff = state_r;
      default: st_eff = ST_PLAIN;
    endcase

    if (!done) begin
      state_nxt = ST_PLAIN;
      if (cls == CL_END) begin
        tail_en = 1'b1;
        tail_k  = KIND_STRING;
      end else begin
        case (st_eff)
          ST_SQ: begin
            if (cls == CL_SQ) state_nxt = ST_PLAIN;
            else begin
              state_nxt = ST_SQ;
              tail_en   = 1'b1;
              tail_b    = in_byte;
            end
          end
          ST_DQ: begin
            if (cls == CL_DQ) state_nxt = ST_PLAIN;
            else begin
              state_nxt = ST_DQ;
              tail_en   = 1'b1;
              tail_b    = in_byte;
            end
          end
          ST_ESC: begin
            tail_en = 1'b1;
            tail_b  = in_byte;
          end
          default: begin
            case (cls)
              CL_SQ:    state_nxt = ST_SQ;
              CL_DQ:    state_nxt = ST_DQ;
              CL_BS:    state_nxt = ST_ESC;
              CL_PCT:   state_nxt = ST_PCT;
              CL_DELIM: begin
                tail_en = 1'b1;
                tail_k  = KIND_TOKEN;
              end
              default: begin
                tail_en = 1'b1;
                tail_b  = in_byte;
              end
            endcase
          end
        endcase
      end
    end
  end

  // pack prefix words and the tail word into consecutive slots
  always_comb begin
    total                = pre_n + {1'b0, tail_en};
    push_bundle          = '0;
    push_bundle.last_idx = total - 2'd1;
    push_bundle.bytes[0] = pre0;
    push_bundle.bytes[1] = pre1;
    case (pre_n)
      2'd0: begin
        push_bundle.bytes[0] = tail_b;
        push_bundle.kinds[0] = tail_k;
      end
      2'd1: begin
        push_bundle.bytes[1] = tail_b;
        push_bundle.kinds[1] = tail_k;
      end
      default: begin
        push_bundle.bytes[2] = tail_b;
        push_bundle.kinds[2] = tail_k;
      end
    endcase
  end

  assign push = accept & (total != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PLAIN;
      held_r  <= 8'h00;
    end else if (accept) begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

/* hw/rtl/qts_fifo.sv */
`timescale 1ns / 1ps
// Short queue of result bundles between front and back end.
// Depends on qts_pkg for the bundle type.
module qts_fifo #(
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  qts_pkg::bundle_t push_data,
  input  logic             pop,
  output qts_pkg::bundle_t head,
  output logic             empty,
  output logic             full
);
  import qts_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bundle_t             mem_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CntW'(Depth));
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* hw/rtl/qts_back.sv */
`timescale 1ns / 1ps
// Back end: walks the head bundle one result per cycle into the output
// register while the output is not stalled. Depends on qts_pkg.
module qts_back (
  input  logic             clk,
  input  logic             rst_n,
  input  qts_pkg::bundle_t head,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic             out_last
);
  import qts_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic [1:0] kind_r;
  logic       last_r;
  logic       load, is_last;

  assign load      = ~q_empty & (~valid_r | out_ready);
  assign is_last   = (idx_r == head.last_idx);
  assign pop       = load & is_last;
  assign idx_nxt   = pop ? 2'd0 : (load ? idx_r + 2'd1 : idx_r);
  assign valid_nxt = load | (valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bytes[idx_r];
      kind_r <= head.kinds[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

endmodule

/* hw/rtl/quoted_token_splitter.sv */
`timescale 1ns / 1ps
// Quoted token splitter: strips quotes and escapes, decodes percent-hex pairs.
// A result goes through the queue and the output register to reach out_valid.
// Throughput: one input word per cycle while the queue has room; the results of
// each word leave the single output register one per cycle while out_ready allows.
// Reset (synchronous, rst_n low): parse state plain, queue empty, delimiter A '/'.
// Depends on qts_pkg, qts_front, qts_fifo, qts_back.
module quoted_token_splitter #(
  parameter int QueueDepth = 2  // bundles between front and back, 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  // input word channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  // result word channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last
);
  import qts_pkg::*;

  delim_set_t delims_r;
  logic       q_push, q_pop, q_empty, q_full;
  bundle_t    push_bundle, q_head;

  // Delimiter registers; a zero entry never matches since a zero byte
  // classifies as end of string first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delims_r <= delim_set_t'({{((NUM_DELIMS - 1) * 8){1'b0}}, DELIM_A_RESET});
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DELIM_A: delims_r[REG_DELIM_A] <= cfg_wdata;
        REG_DELIM_B: delims_r[REG_DELIM_B] <= cfg_wdata;
        REG_DELIM_C: delims_r[REG_DELIM_C] <= cfg_wdata;
        REG_DELIM_D: delims_r[REG_DELIM_D] <= cfg_wdata;
        default: delims_r <= delims_r;
      endcase
    end
  end

  // Front: take a word whenever the queue has room, classify it and
  // advance the parse state. Words that cause no result push nothing.
  qts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .delims     (delims_r),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (q_push),
    .push_bundle(push_bundle)
  );

  // Queue: lets the front keep taking words while a burst drains.
  qts_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_bundle),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: one result per cycle unless stalled; drop the bundle after its last.
  qts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

  // A marker always closes the results of its input word.
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_DATA) |-> out_last)
    else $error("marker result not flagged last");

  // Markers carry a zero byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_DATA) |-> (out_byte == 8'h00))
    else $error("marker result with nonzero byte");

  // A result only appears when the queue held a bundle in the cycle before.
  a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!q_empty))
    else $error("result appeared without a queued bundle");

endmodule

/* verif/quoted_token_splitter_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for quoted_token_splitter: drives character words, predicts the
// token stream in-line, and checks each result word against it. Depends on qts_pkg.
module quoted_token_splitter_test;
  import qts_pkg::*;

  // one expected or observed result word
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } tok_word_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  // token predictor state: delimiter copy, scan state and the byte held after a percent
  delim_set_t   delim_mirror;
  parse_state_t scan_state;
  logic [7:0]   held_char;
  tok_word_t    pending_words[$];

  // idle control for the two sides, and run statistics
  logic idle_on;
  logic stall_on;
  int   chars_sent;
  int   words_checked;
  int   mismatches;
  int   settings_written;

  quoted_token_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Classify with fixed priority: end, quotes, backslash, percent, then delimiters.
  function automatic char_class_t class_of(input logic [7:0] c);
    if (c == CH_END) return CL_END;
    if (c == CH_SQ)  return CL_SQ;
    if (c == CH_DQ)  return CL_DQ;
    if (c == CH_BS)  return CL_BS;
    if (c == CH_PCT) return CL_PCT;
    foreach (delim_mirror[i]) begin
      if (delim_mirror[i] != CH_END && c == delim_mirror[i]) return CL_DELIM;
    end
    return CL_PLAIN;
  endfunction

  // Value of one hex digit, or -1 when the byte is not one.
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  // Advance the scan state by one accepted character and queue the words it emits.
  function automatic void tokenize_char(input logic [7:0] c);
    tok_word_t    burst[$];
    char_class_t  cl;
    parse_state_t st;
    int           hi;
    int           lo;
    cl = class_of(c);
    st = scan_state;
    if (st == ST_PCT && cl == CL_PLAIN) begin
      // hold the first digit; nothing comes out yet
      held_char  = c;
      scan_state = ST_PCT2;
    end else if (st == ST_PCT2 && cl == CL_PLAIN) begin
      hi = nibble_of(held_char);
      lo = nibble_of(c);
      if (hi >= 0 && lo >= 0) begin
        burst.push_back('{8'(hi * 16 + lo), KIND_DATA, 1'b0});
      end else begin
        // not hex: give back the whole sequence untouched
        burst.push_back('{CH_PCT, KIND_DATA, 1'b0});
        burst.push_back('{held_char, KIND_DATA, 1'b0});
        burst.push_back('{c, KIND_DATA, 1'b0});
      end
      held_char  = 8'h00;
      scan_state = ST_PLAIN;
    end else begin
      // a percent sequence broken off early is flushed, then c is taken as plain
      if (st == ST_PCT) begin
        burst.push_back('{CH_PCT, KIND_DATA, 1'b0});
        st = ST_PLAIN;
      end else if (st == ST_PCT2) begin
        burst.push_back('{CH_PCT, KIND_DATA, 1'b0});
        burst.push_back('{held_char, KIND_DATA, 1'b0});
        held_char = 8'h00;
        st = ST_PLAIN;
      end
      if (cl == CL_END) begin
        burst.push_back('{8'h00, KIND_STRING, 1'b0});
        st = ST_PLAIN;
      end else begin
        case (st)
          ST_SQ: begin
            if (cl == CL_SQ) st = ST_PLAIN;
            else burst.push_back('{c, KIND_DATA, 1'b0});
          end
          ST_DQ: begin
            if (cl == CL_DQ) st = ST_PLAIN;
            else burst.push_back('{c, KIND_DATA, 1'b0});
          end
          ST_ESC: begin
            burst.push_back('{c, KIND_DATA, 1'b0});
            st = ST_PLAIN;
          end
          default: begin
            case (cl)
              CL_SQ:    st = ST_SQ;
              CL_DQ:    st = ST_DQ;
              CL_BS:    st = ST_ESC;
              CL_PCT:   st = ST_PCT;
              CL_DELIM: burst.push_back('{8'h00, KIND_TOKEN, 1'b0});
              default:  burst.push_back('{c, KIND_DATA, 1'b0});
            endcase
          end
        endcase
      end
      scan_state = st;
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) pending_words.push_back(burst[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: track config writes, predict on accepted input, check accepted output.
  // Everything here samples values from just before the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tok_word_t got;
    tok_word_t want;
    if (!rst_n) begin
      delim_mirror = '0;
      delim_mirror[REG_DELIM_A] = DELIM_A_RESET;
      scan_state = ST_PLAIN;
      held_char  = 8'h00;
    end else begin
      if (cfg_wr_en) delim_mirror[cfg_index] = cfg_wdata;
      if (in_valid && in_ready) tokenize_char(in_byte);
      if (out_valid && out_ready) begin
        got = '{out_byte, out_kind, out_last};
        words_checked++;
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word byte %02h kind %0d last %0b",
                     $realtime, got.data, got.kind, got.last);
        end else begin
          want = pending_words.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected byte %02h kind %0d last %0b, %s %02h kind %0d last %0b",
                       $realtime, want.data, want.kind, want.last, "got byte",
                       got.data, got.kind, got.last);
          end
        end
      end
    end
  end

  // Receiver: drop ready at random, about 6 percent of the time, while stalling is enabled.
  always @(posedge clk) begin
    out_ready <= !(stall_on && $urandom_range(0, 99) < 6);
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // Send one character word; hold valid and data until the handshake.
  task automatic send_char(input logic [7:0] c);
    while (idle_on && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline settle.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write all four delimiter registers; entry i of the set goes to register i.
  // Call only while the block is drained.
  task automatic write_delims(input delim_set_t d);
    cfg_wr_en <= 1'b1;
    for (int i = 0; i < NUM_DELIMS; i++) begin
      cfg_index <= 2'(i);
      cfg_wdata <= d[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings_written++;
  endtask

  // Delimiter pick weighted toward edge values and the special characters.
  function automatic logic [7:0] pick_delim();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return CH_PCT;
      3:       return CH_SQ;
      4:       return ",";
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Send one random piece of a string: mostly well-formed fragments, some noise.
  task automatic send_piece(input delim_set_t d);
    string      plain_set;
    string      hex_set;
    logic [7:0] q;
    logic [7:0] dl;
    int         r;
    plain_set = "abcdefghijklmnopqrstuvwxyz0123456789-_.:=";
    hex_set   = "0123456789ABCDEFabcdef";
    r = $urandom_range(0, 99);
    if (r < 30) begin
      send_char(plain_set[$urandom_range(0, plain_set.len() - 1)]);
    end else if (r < 40) begin
      dl = d[$urandom_range(0, NUM_DELIMS - 1)];
      send_char(dl == 8'h00 ? 8'h2F : dl);
    end else if (r < 50) begin
      q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
      send_char(q);
      repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(1, 255)));
      send_char(q);
    end else if (r < 58) begin
      send_char(CH_BS);
      send_char(8'($urandom_range(1, 255)));
    end else if (r < 72) begin
      send_char(CH_PCT);
      send_char(hex_set[$urandom_range(0, hex_set.len() - 1)]);
      send_char(hex_set[$urandom_range(0, hex_set.len() - 1)]);
    end else if (r < 78) begin
      // percent followed by zero or one digit, then a random byte
      send_char(CH_PCT);
      if ($urandom_range(0, 1)) send_char(hex_set[$urandom_range(0, hex_set.len() - 1)]);
      send_char(8'($urandom_range(0, 255)));
    end else if (r < 82) begin
      send_char(CH_END);
    end else begin
      send_char(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default delimiter '/': plain, token end, quotes with specials inside, escape.
  task automatic test_quotes_and_escape();
    send_text("a/'x%'\"q'\"\\\"");
    wait_until_drained();
  endtask

  // Percent decoding: lower-case hex, decoded zero, bad digits, broken sequences.
  task automatic test_percent_sequences();
    send_text("%4a%00%zG%4/%");
    send_char(CH_END);
    wait_until_drained();
  endtask

  // Special characters loaded as delimiters stay special; zero ends quotes and escapes.
  task automatic test_special_delims();
    delim_set_t d;
    d[REG_DELIM_A] = 8'h00;
    d[REG_DELIM_B] = 8'hFF;
    d[REG_DELIM_C] = CH_PCT;
    d[REG_DELIM_D] = CH_SQ;
    write_delims(d);
    send_char(8'hFF);
    send_char(CH_SQ);
    send_char(CH_END);
    send_char(CH_BS);
    send_char(CH_END);
    wait_until_drained();
  endtask

  // Random strings over four delimiter settings; the third runs at full rate.
  task automatic test_random_streams();
    delim_set_t d;
    int         base;
    bit         paused;
    base   = chars_sent;
    paused = 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 1) begin
        d[REG_DELIM_A] = 8'hFF;
        d[REG_DELIM_B] = 8'h01;
        d[REG_DELIM_C] = CH_BS;
        d[REG_DELIM_D] = ";";
      end else if (phase == 3) begin
        d = '0;  // no delimiters at all
      end else begin
        foreach (d[i]) d[i] = pick_delim();
      end
      write_delims(d);
      idle_on  = (phase != 2);
      stall_on = (phase != 2);
      while (chars_sent - base < (phase + 1) * 95) begin
        send_piece(d);
        // hold off the sender once mid-stream until the output has caught up
        if (phase == 1 && !paused && chars_sent - base >= 140) begin
          wait_until_drained();
          paused = 1'b1;
        end
      end
      wait_until_drained();
    end
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = REG_DELIM_A;
    cfg_wdata        = 8'h00;
    in_valid         = 1'b0;
    in_byte          = 8'h00;
    out_ready        = 1'b0;
    idle_on          = 1'b1;
    stall_on         = 1'b1;
    chars_sent       = 0;
    words_checked    = 0;
    mismatches       = 0;
    settings_written = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_quotes_and_escape();
    test_percent_sequences();
    test_special_delims();
    test_random_streams();

    $display("Sent %0d characters over %0d delimiter settings; checked %0d result words.",
             chars_sent, settings_written, words_checked);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("Failures: %0d mismatched or unexpected words, %0d still expected.",
               mismatches, pending_words.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d words still expected.", pending_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
